>>> rtl/core/msws_pkg.sv
// Shared constants, register codes and status types for the max square window sum block.
`timescale 1ns / 1ps
package msws_pkg;

    localparam int MAX_GRID_DEF   = 64;
    localparam int VALUE_BITS_DEF = 8;

    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CELL_W      = 8;
    localparam int MAX_SUM_W   = 20;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_W-1:0] GRID_SIZE_RST   = 7'd5;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE   = 1'b0,
        REG_WINDOW_SIZE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_pipe_stat;

endpackage

>>> rtl/core/max_square_window_sum_top.sv
// Top level of the max square window sum block: configuration, input flow control, result queue.
// Usage:
//   Cells of a grid_size x grid_size grid stream in on the s_axis side, one beat per cell
//   in raster order, value in tdata. After the beat that carries the last cell, one beat
//   with the largest window_size x window_size window sum leaves on the m_axis side
//   (zero when the window does not fit the grid); then the next grid starts.
//   Configuration writes (index 0: grid_size, index 1: window_size) take effect at once
//   and drop any grid in progress; write them only while no grid is in flight.
// Timing:
//   One beat per clock is accepted while s_axis tready is high. A cell passes a grid read
//   and a column-sum read-modify-write in one stage and the row window update in the next;
//   the result beat is offered once the last cell has passed both stages and entered the queue.
//   The rate is set by the single write port of the grid memory and of each column-sum copy.
// Reset:
//   Sets grid_size to 5, window_size to 2, and clears positions, sums and queue.
// Stalls:
//   Results wait in a 4-entry queue; s_axis tready drops while the queue plus the cells
//   still in the pipeline would fill it, so nothing is lost while m_axis tready is low.
`timescale 1ns / 1ps
module max_square_window_sum_top #(
    parameter int MAX_GRID   = msws_pkg::MAX_GRID_DEF,
    parameter int VALUE_BITS = msws_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msws_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [msws_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] cell_value
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [msws_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // [19:0] max_sum, rest zero
);

    import msws_pkg::*;

    logic [CFG_W-1:0]      r_grid_size, n_grid_size;
    logic [CFG_W-1:0]      r_window_size, n_window_size;
    logic                  in_beat;
    t_pipe_stat            stat;
    logic                  res_valid;
    logic [MAX_SUM_W-1:0]  res_sum;
    logic [MAX_SUM_W-1:0]  out_sum;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   slots_used;

    always_comb begin
        n_grid_size   = r_grid_size;
        n_window_size = r_window_size;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GRID_SIZE: begin
                    n_grid_size = i_cfg_wdata;
                end
                REG_WINDOW_SIZE: begin
                    n_window_size = i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size   <= GRID_SIZE_RST;
            r_window_size <= WINDOW_SIZE_RST;
        end else begin
            r_grid_size   <= n_grid_size;
            r_window_size <= n_window_size;
        end
    end

    // Every cell in the pipeline may turn into a result, so it holds a queue slot.
    assign slots_used = (FIFO_CNT_W + 1)'(fifo_count)
                      + (FIFO_CNT_W + 1)'(stat.s1_valid)
                      + (FIFO_CNT_W + 1)'(stat.s2_valid);
    assign o_s_axis_tready = (slots_used < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    msws_core #(
        .MAX_GRID   (MAX_GRID),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (i_cfg_we),
        .i_grid_size   (r_grid_size),
        .i_window_size (r_window_size),
        .i_valid       (in_beat),
        .i_cell        (i_s_axis_tdata[CELL_W-1:0]),
        .o_stat        (stat),
        .o_res_valid   (res_valid),
        .o_res_sum     (res_sum)
    );

    msws_out_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (MAX_SUM_W),
        .CNT_W (FIFO_CNT_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_sum),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_sum),
        .o_count (fifo_count)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'(out_sum);

endmodule

>>> rtl/core/msws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module msws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/msws_out_fifo.sv
// Small result queue that decouples the sum pipeline from the output channel.
`timescale 1ns / 1ps
module msws_out_fifo #(
    parameter int DEPTH = msws_pkg::FIFO_DEPTH,
    parameter int WIDTH = msws_pkg::MAX_SUM_W,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data,
    output logic [CNT_W-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // The input side holds back beats so that every result in flight has a slot.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNT_W'(DEPTH))))
        else $error("result queue overflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_push && !pop)) |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("result queue count lost a push");

endmodule

>>> rtl/core/msws_core.sv
// Position counters and the three-stage read-modify-write pipeline over the grid and column sums.
`timescale 1ns / 1ps
module msws_core #(
    parameter int MAX_GRID   = msws_pkg::MAX_GRID_DEF,
    parameter int VALUE_BITS = msws_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic [msws_pkg::CFG_W-1:0]     i_grid_size,
    input  logic [msws_pkg::CFG_W-1:0]     i_window_size,
    input  logic                           i_valid,
    input  logic [msws_pkg::CELL_W-1:0]    i_cell,
    output msws_pkg::t_pipe_stat           o_stat,
    output logic                           o_res_valid,
    output logic [msws_pkg::MAX_SUM_W-1:0] o_res_sum
);

    import msws_pkg::*;

    localparam int POS_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int GA_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID * MAX_GRID) : 1;
    localparam int CMP_W = ((POS_W + 1) > CFG_W) ? (POS_W + 1) : CFG_W;
    localparam int COL_W = VALUE_BITS + POS_W;
    localparam int SUM_W = VALUE_BITS + 2 * POS_W;
    localparam int SUM_X = (SUM_W > MAX_SUM_W) ? SUM_W : MAX_SUM_W;
    localparam int IN_W  = (VALUE_BITS < CELL_W) ? VALUE_BITS : CELL_W;

    // Accept stage.
    logic [POS_W-1:0]      r_row, n_row;
    logic [POS_W-1:0]      r_col, n_col;
    logic [CMP_W-1:0]      g_raw, g_eff, w, row_x, col_x;
    logic                  win_ok, row_ge_w, col_ge_w, in_win, col_end, row_end;
    logic [VALUE_BITS-1:0] cell_v;
    logic [POS_W-1:0]      old_row, colw_addr;
    logic [GA_W-1:0]       grid_waddr, grid_raddr;
    logic                  fwd_a, fwd_b;

    // Column-sum stage.
    logic                  r_s1_valid;
    logic [VALUE_BITS-1:0] r_s1_v;
    logic                  r_s1_first_row, r_s1_sub, r_s1_first_col, r_s1_col_ge_w;
    logic                  r_s1_in_win, r_s1_last, r_s1_wv, r_s1_fwd_a, r_s1_fwd_b;
    logic [POS_W-1:0]      r_s1_col;
    logic [VALUE_BITS-1:0] grid_rd;
    logic [COL_W-1:0]      col_a_rd, col_b_rd, col_a_val, col_b_val;
    logic [COL_W-1:0]      col_base, col_drop, col_new;
    logic                  col_we;

    // Row-window stage.
    logic                  r_s2_valid;
    logic                  r_s2_first_col, r_s2_col_ge_w, r_s2_in_win, r_s2_last, r_s2_wv;
    logic [COL_W-1:0]      r_s2_col, r_s2_colw;
    logic [SUM_W-1:0]      r_rws, r_best;
    logic [SUM_W-1:0]      rws_base, rws_drop, rws_new, best_new;
    logic [SUM_X-1:0]      best_x;

    assign g_raw = CMP_W'(i_grid_size);
    assign w     = CMP_W'(i_window_size);
    assign g_eff = (g_raw == '0) ? CMP_W'(1) :
                   (g_raw > CMP_W'(MAX_GRID)) ? CMP_W'(MAX_GRID) : g_raw;
    assign row_x = CMP_W'(r_row);
    assign col_x = CMP_W'(r_col);

    assign win_ok   = (w != '0) && (w <= g_eff);
    assign row_ge_w = (row_x >= w);
    assign col_ge_w = (col_x >= w);
    assign in_win   = ((row_x + CMP_W'(1)) >= w) && ((col_x + CMP_W'(1)) >= w);
    assign col_end  = ((col_x + CMP_W'(1)) >= g_eff);
    assign row_end  = ((row_x + CMP_W'(1)) >= g_eff);

    assign cell_v     = VALUE_BITS'(i_cell[IN_W-1:0]);
    assign old_row    = POS_W'(row_x - w);
    assign colw_addr  = POS_W'(col_x - w);
    assign grid_waddr = GA_W'(r_row) * GA_W'(MAX_GRID) + GA_W'(r_col);
    assign grid_raddr = GA_W'(old_row) * GA_W'(MAX_GRID) + GA_W'(r_col);

    // The item one ahead writes its column sum at the edge this item reads; take it
    // from the stage-two register instead.
    assign fwd_a = r_s1_valid && r_s1_wv && (r_s1_col == r_col);
    assign fwd_b = r_s1_valid && r_s1_wv && (r_s1_col == colw_addr);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_clear) begin
            n_row = '0;
            n_col = '0;
        end else if (i_valid) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : POS_W'(row_x + CMP_W'(1));
            end else begin
                n_col = POS_W'(col_x + CMP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_v         <= cell_v;
        r_s1_first_row <= (r_row == '0);
        r_s1_sub       <= row_ge_w;
        r_s1_first_col <= (r_col == '0);
        r_s1_col_ge_w  <= col_ge_w;
        r_s1_in_win    <= in_win;
        r_s1_last      <= col_end && row_end;
        r_s1_wv        <= win_ok;
        r_s1_fwd_a     <= fwd_a;
        r_s1_fwd_b     <= fwd_b;
        r_s1_col       <= r_col;

        r_s2_first_col <= r_s1_first_col;
        r_s2_col_ge_w  <= r_s1_col_ge_w;
        r_s2_in_win    <= r_s1_in_win;
        r_s2_last      <= r_s1_last;
        r_s2_wv        <= r_s1_wv;
        r_s2_col       <= col_new;
        r_s2_colw      <= col_b_val;
    end

    msws_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_GRID * MAX_GRID)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (i_valid),
        .i_waddr (grid_waddr),
        .i_wdata (cell_v),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rd)
    );

    // Two identical copies of the column sums give one read at the current column
    // and one at the column that leaves the window.
    msws_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_GRID)
    ) u_col_a (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_s1_col),
        .i_wdata (col_new),
        .i_raddr (r_col),
        .o_rdata (col_a_rd)
    );

    msws_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_GRID)
    ) u_col_b (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_s1_col),
        .i_wdata (col_new),
        .i_raddr (colw_addr),
        .o_rdata (col_b_rd)
    );

    // On the first row of a grid the column sum starts from zero, so the stored
    // sums never need a clearing pass.
    assign col_a_val = r_s1_fwd_a ? r_s2_col : col_a_rd;
    assign col_b_val = r_s1_fwd_b ? r_s2_col : col_b_rd;
    assign col_base  = r_s1_first_row ? '0 : col_a_val;
    assign col_drop  = r_s1_sub ? COL_W'(grid_rd) : '0;
    assign col_new   = col_base + COL_W'(r_s1_v) - col_drop;
    assign col_we    = r_s1_valid && r_s1_wv;

    assign rws_base = r_s2_first_col ? '0 : r_rws;
    assign rws_drop = r_s2_col_ge_w ? SUM_W'(r_s2_colw) : '0;
    assign rws_new  = rws_base + SUM_W'(r_s2_col) - rws_drop;
    assign best_new = (r_s2_wv && r_s2_in_win && (rws_new > r_best)) ? rws_new : r_best;
    assign best_x   = SUM_X'(best_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_rws  <= '0;
            r_best <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_wv) begin
                r_rws <= rws_new;
            end
            r_best <= r_s2_last ? '0 : best_new;
        end
    end

    assign o_res_valid = r_s2_valid && r_s2_last;
    assign o_res_sum   = best_x[MAX_SUM_W-1:0];

    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.s2_valid = r_s2_valid;

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_fwd_a || r_s1_fwd_b)) |-> (r_s2_valid && r_s2_wv))
        else $error("column sum forwarded from an empty stage");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_x < g_eff) && (col_x < g_eff))
        else $error("grid position outside the grid");

endmodule
